// ----- src/mfu_cache_replacement_assert.svh -----
// Assertion macros for the cache block. Each macro checks one property on
// the rising clock edge, with the asynchronous reset disabling the check.
`ifndef MFU_CACHE_REPLACEMENT_ASSERT_SVH
`define MFU_CACHE_REPLACEMENT_ASSERT_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define MFU_ASSERT_SAME(label, clk_i, rst_n_i, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
		else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define MFU_ASSERT_NEXT(label, clk_i, rst_n_i, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MFU_ASSERT_SAME(label, clk_i, rst_n_i, ante, cons, msg)
`define MFU_ASSERT_NEXT(label, clk_i, rst_n_i, ante, cons, msg)
`endif
`endif

// ----- src/mfu_pkg.sv -----
package mfu_pkg;

	// Operation carried by an input beat.
	typedef enum logic {
		OP_PUT = 1'b0,
		OP_GET = 1'b1
	} op_t;

	typedef logic signed [31:0] key_t;
	typedef logic [31:0] word_t;
	typedef logic [15:0] count_t;

	// Use counts stop here and do not wrap.
	localparam count_t COUNT_MAX = 16'hFFFF;

	// Width and reset value of the entry limit register.
	localparam int LIMIT_W = 4;
	typedef logic [LIMIT_W-1:0] limit_t;
	localparam limit_t LIMIT_RESET = 4'd8;

endpackage

// ----- src/mfu_way_match.sv -----
module mfu_way_match #(
	parameter int WAYS = 8
) (
	input  logic [WAYS-1:0] valid,
	input  mfu_pkg::key_t   entry_key [WAYS],
	input  mfu_pkg::key_t   key,
	output logic [WAYS-1:0] match
);
	import mfu_pkg::*;

	// Compare the looked-up key against every valid way in parallel. Keys are
	// only inserted on a miss, so at most one way can match.
	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			match[i] = valid[i] && (entry_key[i] == key);
		end
	end

endmodule

// ----- src/mfu_victim_sel.sv -----
module mfu_victim_sel #(
	parameter int WAYS = 8,
	parameter int RW   = 3
) (
	input  logic [WAYS-1:0]   valid,
	input  mfu_pkg::count_t   use_count [WAYS],
	input  logic [RW-1:0]     rank [WAYS],
	output logic [WAYS-1:0]   victim
);
	import mfu_pkg::*;

	// Pairwise comparison: a way is the victim when it beats every other valid
	// way, either by a higher count or, on equal counts, by an older rank.
	// Ranks of valid ways are distinct, so the result is one-hot or empty.
	always_comb begin
		victim = valid;
		for (int i = 0; i < WAYS; i++) begin
			for (int j = 0; j < WAYS; j++) begin
				if ((i != j) && valid[j] &&
				    !((use_count[i] > use_count[j]) ||
				      ((use_count[i] == use_count[j]) && (rank[i] < rank[j])))) begin
					victim[i] = 1'b0;
				end
			end
		end
	end

endmodule

// ----- src/mfu_cache_replacement.sv -----
// Fully associative key-value cache with most-frequently-used eviction.
// An input beat is taken at every clock edge where start is high; busy is
// always low, so a new put or get may be issued in every cycle, one item per
// cycle sustained. Each item gives exactly one result beat, marked by done:
// the item passes through the input register, where the way match, victim
// selection and state update settle, and then through the result register.
// The receiver cannot stall: done is high for exactly one cycle and the
// result must be taken then. The entry limit is written through cfg_wr_en
// and cfg_wr_data; the user must do so only while no item is in flight,
// which the block itself does not enforce. A limit of zero acts as one and
// a limit above the number of ways acts as the number of ways.
`include "mfu_cache_replacement_assert.svh"

module mfu_cache_replacement #(
	parameter int WAYS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  mfu_pkg::op_t        op,
	input  mfu_pkg::key_t       key,
	input  mfu_pkg::word_t      value,
	input  logic                cfg_wr_en,
	input  mfu_pkg::limit_t     cfg_wr_data,
	output logic                done,
	output logic                hit,
	output logic                evicted,
	output mfu_pkg::key_t       evicted_key,
	output mfu_pkg::word_t      read_value
);
	import mfu_pkg::*;

	localparam int OW = $clog2(WAYS + 1);
	localparam int RW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int LW = (OW > LIMIT_W) ? OW : LIMIT_W;

	// Control state.
	limit_t          limit_q;
	logic [WAYS-1:0] valid_q;
	logic [OW-1:0]   occ_q;

	// Entry storage, one register per way.
	key_t            ekey_q   [WAYS];
	word_t           evalue_q [WAYS];
	count_t          cnt_q    [WAYS];
	logic [RW-1:0]   rank_q   [WAYS];

	// Input register.
	logic            req_vld_s1;
	op_t             op_s1;
	key_t            key_s1;
	word_t           value_s1;

	// Result register.
	logic            done_s2;
	logic            hit_s2;
	logic            evicted_s2;
	key_t            evkey_s2;
	word_t           rdval_s2;

	// Decode signals.
	logic [WAYS-1:0] match_vec;
	logic [WAYS-1:0] victim_vec;
	logic [WAYS-1:0] free_vec;
	logic [WAYS-1:0] slot_vec;
	logic [WAYS-1:0] gap_src;
	logic            is_hit;
	logic [LW-1:0]   lim_eff;
	logic            full;
	logic            put_miss;
	logic            do_hit;
	logic            do_evict;
	logic            do_insert;
	logic [OW-1:0]   occ_next;
	logic [RW-1:0]   hit_rank;
	logic [RW-1:0]   new_rank;
	logic [RW-1:0]   gap_rank;
	word_t           sel_value;
	key_t            sel_evkey;

	// Every cycle can take a new beat.
	assign busy = 1'b0;

	mfu_way_match #(
		.WAYS (WAYS)
	) u_match (
		.valid     (valid_q),
		.entry_key (ekey_q),
		.key       (key_s1),
		.match     (match_vec)
	);

	mfu_victim_sel #(
		.WAYS (WAYS),
		.RW   (RW)
	) u_victim (
		.valid     (valid_q),
		.use_count (cnt_q),
		.rank      (rank_q),
		.victim    (victim_vec)
	);

	// Effective limit, clamped to the range one to the number of ways.
	always_comb begin
		lim_eff = LW'(limit_q);
		if (lim_eff == '0) begin
			lim_eff = LW'(1);
		end
		if (lim_eff > LW'(WAYS)) begin
			lim_eff = LW'(WAYS);
		end
	end

	// Decide what the item in the input register does to the cache.
	assign is_hit    = |match_vec;
	assign full      = LW'(occ_q) >= lim_eff;
	assign put_miss  = req_vld_s1 && !is_hit && (op_s1 == OP_PUT);
	assign do_hit    = req_vld_s1 && is_hit;
	assign do_evict  = put_miss && full && (|victim_vec);
	assign free_vec  = ~valid_q | (do_evict ? victim_vec : '0);
	assign slot_vec  = free_vec & (~free_vec + WAYS'(1));
	assign do_insert = put_miss && (|free_vec);
	assign occ_next  = occ_q - OW'(do_evict) + OW'(do_insert);
	assign hit_rank  = RW'(occ_q - OW'(1));
	assign new_rank  = RW'(occ_next - OW'(1));
	assign gap_src   = do_hit ? match_vec : victim_vec;

	// One-hot selection of the hit value, the evicted key and the rank whose
	// gap is closed.
	always_comb begin
		sel_value = '0;
		sel_evkey = '0;
		gap_rank  = '0;
		for (int i = 0; i < WAYS; i++) begin
			if (match_vec[i]) begin
				sel_value = sel_value | evalue_q[i];
			end
			if (victim_vec[i]) begin
				sel_evkey = sel_evkey | ekey_q[i];
			end
			if (gap_src[i]) begin
				gap_rank = gap_rank | rank_q[i];
			end
		end
	end

	// Control registers with reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= LIMIT_RESET;
			valid_q    <= '0;
			occ_q      <= '0;
			req_vld_s1 <= 1'b0;
			done_s2    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			req_vld_s1 <= start && !busy;
			done_s2    <= req_vld_s1;
			occ_q      <= occ_next;
			for (int i = 0; i < WAYS; i++) begin
				if (do_insert && slot_vec[i]) begin
					valid_q[i] <= 1'b1;
				end else if (do_evict && victim_vec[i]) begin
					valid_q[i] <= 1'b0;
				end
			end
		end
	end

	// Entry payload: the touched way becomes newest and counts up, a new
	// entry starts at count one, and ranks above a closed gap move down.
	always_ff @(posedge clk) begin
		for (int i = 0; i < WAYS; i++) begin
			if (do_hit && match_vec[i]) begin
				rank_q[i] <= hit_rank;
				if (cnt_q[i] != COUNT_MAX) begin
					cnt_q[i] <= cnt_q[i] + count_t'(1);
				end
			end else if (do_insert && slot_vec[i]) begin
				ekey_q[i]   <= key_s1;
				evalue_q[i] <= value_s1;
				cnt_q[i]    <= count_t'(1);
				rank_q[i]   <= new_rank;
			end else if ((do_hit || do_evict) && valid_q[i] && (rank_q[i] > gap_rank)) begin
				rank_q[i] <= rank_q[i] - RW'(1);
			end
		end
	end

	// Input and result payload registers.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1    <= op;
			key_s1   <= key;
			value_s1 <= value;
		end
		hit_s2     <= is_hit;
		evicted_s2 <= do_evict;
		evkey_s2   <= do_evict ? sel_evkey : '0;
		rdval_s2   <= is_hit ? sel_value : '0;
	end

	assign done        = done_s2;
	assign hit         = hit_s2;
	assign evicted     = evicted_s2;
	assign evicted_key = evkey_s2;
	assign read_value  = rdval_s2;

	// Checks on the block's own bookkeeping.
	`MFU_ASSERT_SAME(a_occ_matches_valid, clk, arst_n, 1'b1, ($countones(valid_q) == occ_q), "occupancy differs from number of valid ways")
	`MFU_ASSERT_SAME(a_occ_bounded, clk, arst_n, 1'b1, (occ_q <= OW'(WAYS)), "occupancy above number of ways")
	`MFU_ASSERT_SAME(a_evict_not_hit, clk, arst_n, (done && evicted), (!hit), "eviction reported on a hit")
	`MFU_ASSERT_NEXT(a_item_gives_result, clk, arst_n, req_vld_s1, done, "accepted beat gave no result")

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mfu_pkg::*;

	localparam int WAYS = 8;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 800;
	localparam int RANDOM_PHASES = 8;
	localparam int POOL_SIZE = 12;
	// Hits used to build up the counts of the two tie-break entries.
	localparam int COUNT_HITS = 16;

	// One result beat as seen on the output ports.
	typedef struct packed {
		logic  hit;
		logic  evicted;
		key_t  evicted_key;
		word_t read_value;
	} lookup_t;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    start;
	logic    busy;
	op_t     op;
	key_t    key;
	word_t   value;
	logic    cfg_wr_en;
	limit_t  cfg_wr_data;
	logic    done;
	logic    hit;
	logic    evicted;
	key_t    evicted_key;
	word_t   read_value;

	// Predicted cache contents and the limit currently programmed.
	logic        way_valid [WAYS];
	key_t        way_key   [WAYS];
	word_t       way_value [WAYS];
	count_t      way_count [WAYS];
	int unsigned way_rank  [WAYS];
	int unsigned fill_level;
	limit_t      limit_reg;

	lookup_t pending_lookups [$];

	int errors = 0;
	int sent_count = 0;
	int results_seen = 0;
	int hit_count = 0;
	int evict_count = 0;
	int limit_writes = 0;
	int cycle_count = 0;
	int burst_left = 0;
	bit pacing_on = 1'b1;

	mfu_cache_replacement #(
		.WAYS(WAYS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.key(key),
		.value(value),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.done(done),
		.hit(hit),
		.evicted(evicted),
		.evicted_key(evicted_key),
		.read_value(read_value)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Give up if the run hangs.
	initial begin
		wait (cycle_count == CYCLE_LIMIT);
		$display("%0t: timeout after %0d cycles, %0d results outstanding", $realtime,
			cycle_count, pending_lookups.size());
		$display("DONE: errors detected");
		$finish;
	end

	// Every valid entry ranked above r moves down one place.
	function automatic void shift_ranks_down(input int unsigned r);
		for (int i = 0; i < WAYS; i++) begin
			if (way_valid[i] && way_rank[i] > r) begin
				way_rank[i] = way_rank[i] - 1;
			end
		end
	endfunction

	// Work out the result of one access and move the predicted state on.
	function automatic lookup_t predict_access(input op_t a_op, input key_t a_key,
		input word_t a_val);
		lookup_t     res;
		int          found;
		int          slot;
		int          victim;
		int unsigned lim;
		res = '0;
		found = -1;
		slot = -1;
		victim = -1;
		for (int i = 0; i < WAYS; i++) begin
			if (found < 0 && way_valid[i] && way_key[i] == a_key) begin
				found = i;
			end
		end
		// A hit of either kind refreshes recency and bumps the count.
		if (found >= 0) begin
			shift_ranks_down(way_rank[found]);
			way_rank[found] = fill_level - 1;
			if (way_count[found] != COUNT_MAX) begin
				way_count[found] = way_count[found] + 1'b1;
			end
			res.hit = 1'b1;
			res.read_value = way_value[found];
			return res;
		end
		if (a_op == OP_GET) begin
			return res;
		end
		lim = limit_reg;
		if (lim == 0) begin
			lim = 1;
		end
		if (lim > WAYS) begin
			lim = WAYS;
		end
		// Evict the highest count; on a tie the least recently touched entry.
		if (fill_level >= lim) begin
			for (int i = 0; i < WAYS; i++) begin
				if (way_valid[i]) begin
					if (victim < 0 || way_count[i] > way_count[victim] ||
						(way_count[i] == way_count[victim] &&
						way_rank[i] < way_rank[victim])) begin
						victim = i;
					end
				end
			end
			if (victim >= 0) begin
				shift_ranks_down(way_rank[victim]);
				way_valid[victim] = 1'b0;
				fill_level = fill_level - 1;
				res.evicted = 1'b1;
				res.evicted_key = way_key[victim];
			end
		end
		for (int i = 0; i < WAYS; i++) begin
			if (slot < 0 && !way_valid[i]) begin
				slot = i;
			end
		end
		if (slot >= 0) begin
			way_valid[slot] = 1'b1;
			way_key[slot] = a_key;
			way_value[slot] = a_val;
			way_count[slot] = 16'd1;
			fill_level = fill_level + 1;
			way_rank[slot] = fill_level - 1;
		end
		return res;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
		end
	endtask

	// Each result beat is compared with the oldest outstanding prediction.
	always @(posedge clk) begin
		lookup_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pending_lookups.size() == 0) begin
				errors++;
				$display("%0t: result beat with none expected, expected none, actual %b %b %h %h",
					$realtime, hit, evicted, evicted_key, read_value);
			end else begin
				want = pending_lookups.pop_front();
				results_seen++;
				if (hit === 1'b1) hit_count++;
				if (evicted === 1'b1) evict_count++;
				check_field("hit", want.hit, hit);
				check_field("evicted", want.evicted, evicted);
				check_field("evicted_key", want.evicted_key, evicted_key);
				check_field("read_value", want.read_value, read_value);
			end
		end
	end

	// Drop start for the requested number of cycles.
	task automatic hold_start(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Bursts of back-to-back beats separated by random gaps.
	task automatic pace_sender();
		if (!pacing_on) begin
			return;
		end
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		hold_start($urandom_range(1, 6));
		burst_left = $urandom_range(0, 15);
	endtask

	// Present one access and wait until the block takes it.
	task automatic send_access(input op_t a_op, input key_t a_key, input word_t a_val);
		start <= 1'b1;
		op <= a_op;
		key <= a_key;
		value <= a_val;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_lookups.push_back(predict_access(a_op, a_key, a_val));
		sent_count++;
		pace_sender();
	endtask

	// Stop sending and wait until every predicted result has arrived.
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (pending_lookups.size() != 0);
	endtask

	// The limit is only changed while nothing is in flight.
	task automatic write_limit(input limit_t lim);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= lim;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		limit_reg = lim;
		limit_writes++;
	endtask

	// Two entries built up to equal counts, the older one touched last; the
	// tie must go to the other one, then the highest count goes next.
	task automatic test_count_tie_break();
		key_t first_key;
		key_t second_key;
		first_key = $urandom();
		second_key = first_key ^ 32'h0000_0100;
		pacing_on = 1'b0;
		write_limit(4'd4);
		send_access(OP_PUT, first_key, $urandom());
		repeat (COUNT_HITS) send_access(OP_GET, first_key, $urandom());
		send_access(OP_PUT, second_key, $urandom());
		repeat (COUNT_HITS + 1) send_access(OP_GET, second_key, $urandom());
		send_access(OP_GET, first_key, $urandom());
		send_access(OP_PUT, 32'h0000_00C0, $urandom());
		repeat (3) send_access(OP_GET, 32'h0000_00C0, $urandom());
		send_access(OP_PUT, 32'h0000_00D0, $urandom());
		send_access(OP_PUT, 32'h0000_00E0, $urandom());
		send_access(OP_PUT, 32'h0000_00F0, $urandom());
		pacing_on = 1'b1;
	endtask

	// Field extremes, both operations, a get miss and a put on a present key.
	task automatic test_field_extremes();
		write_limit(4'd15);
		send_access(OP_PUT, 32'h8000_0000, 32'h0000_0000);
		send_access(OP_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_access(OP_PUT, 32'h0000_0000, 32'hA5A5_A5A5);
		send_access(OP_PUT, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
		send_access(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
		send_access(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		send_access(OP_GET, 32'h1234_5678, 32'h0000_0000);
		send_access(OP_PUT, 32'h0000_0000, 32'h0000_0001);
		send_access(OP_GET, 32'h0000_0000, 32'h0000_0000);
	endtask

	// Limit dropped below the number of live entries: one eviction per miss.
	task automatic test_limit_lowered();
		write_limit(4'd2);
		send_access(OP_PUT, 32'h0000_0A01, $urandom());
		send_access(OP_PUT, 32'h0000_0A02, $urandom());
		send_access(OP_PUT, 32'h0000_0A03, $urandom());
	endtask

	// A limit of zero behaves as one.
	task automatic test_limit_zero();
		write_limit(4'd0);
		send_access(OP_PUT, 32'h0000_0B01, $urandom());
		send_access(OP_PUT, 32'h0000_0B02, $urandom());
	endtask

	// A limit above the number of ways behaves as the number of ways.
	task automatic test_limit_above_ways();
		write_limit(4'd15);
		send_access(OP_PUT, 32'h0000_0C01, $urandom());
		send_access(OP_PUT, 32'h0000_0C02, $urandom());
		send_access(OP_PUT, 32'h0000_0C03, $urandom());
		send_access(OP_PUT, 32'h0000_0C04, $urandom());
		send_access(OP_PUT, 32'h0000_0C05, $urandom());
		send_access(OP_GET, 32'h0000_0C01, $urandom());
	endtask

	// Mixed traffic over a small key pool so that hits, count build-up and
	// evictions are frequent, in phases with different limits.
	task automatic test_random_traffic();
		limit_t phase_limits [RANDOM_PHASES];
		key_t   key_pool [POOL_SIZE];
		phase_limits = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5, 4'd2};
		phase_limits[5] = $urandom_range(1, 8);
		for (int j = 0; j < POOL_SIZE; j++) begin
			key_pool[j] = $urandom();
		end
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			write_limit(phase_limits[ph]);
			// Keep part of the pool so that live entries are hit again.
			for (int j = POOL_SIZE / 2; j < POOL_SIZE; j++) begin
				key_pool[j] = $urandom();
			end
			pacing_on = (ph % 3 != 2);
			for (int n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++) begin
				key_t pick;
				op_t  kind;
				if (ph == 2 && n == 50) begin
					drain_results();
				end
				kind = ($urandom_range(0, 9) < 4) ? OP_GET : OP_PUT;
				case ($urandom_range(0, 9))
					0, 1, 2, 3: pick = key_pool[$urandom_range(0, 3)];
					4, 5, 6, 7, 8: pick = key_pool[$urandom_range(0, POOL_SIZE - 1)];
					default: pick = $urandom();
				endcase
				send_access(kind, pick, $urandom());
			end
		end
		pacing_on = 1'b1;
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		op <= OP_PUT;
		key <= '0;
		value <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		for (int i = 0; i < WAYS; i++) begin
			way_valid[i] = 1'b0;
			way_key[i] = '0;
			way_value[i] = '0;
			way_count[i] = '0;
			way_rank[i] = 0;
		end
		fill_level = 0;
		limit_reg = LIMIT_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_count_tie_break();
		test_field_extremes();
		test_limit_lowered();
		test_limit_zero();
		test_limit_above_ways();
		test_random_traffic();

		drain_results();
		repeat (8) @(posedge clk);
		$display("Checked %0d result beats from %0d accesses (%0d hits, %0d evictions).",
			results_seen, sent_count, hit_count, evict_count);
		$display("Limit written %0d times, count tie-breaks and limit extremes included.",
			limit_writes);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ----- mfu_cache_replacement.f -----
+incdir+src
src/mfu_pkg.sv
src/mfu_way_match.sv
src/mfu_victim_sel.sv
src/mfu_cache_replacement.sv
tb/sv/tb_top.sv
